// File: hw/rtl/mersenne_twister_generator_assert.svh
// Assertion macros for the generator.
`ifndef MERSENNE_TWISTER_GENERATOR_ASSERT_SVH
`define MERSENNE_TWISTER_GENERATOR_ASSERT_SVH

// same-cycle implication
`define MTG_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication violated");

// next-cycle implication
`define MTG_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication violated");

`endif

// File: hw/rtl/mtg_pkg.sv
package mtg_pkg;

   localparam int unsigned STATE_DEPTH = 624;
   localparam int unsigned SHIFT_DIST  = 397;
   localparam int unsigned DATA_W      = 32;
   localparam int unsigned IDX_W       = $clog2(STATE_DEPTH);
   localparam int unsigned DIV_CNT_W   = $clog2(DATA_W);

   typedef logic [DATA_W-1:0] word_type;
   typedef logic [IDX_W-1:0]  idx_type;
   typedef logic [1:0]        cmd_type;

   localparam word_type INIT_MULT = 32'd1812433253;
   localparam word_type TWIST_MAT = 32'h9908_B0DF;
   localparam word_type TEMPER_B  = 32'h9D2C_5680;
   localparam word_type TEMPER_C  = 32'hEFC6_0000;
   localparam word_type HIGH_BIT  = 32'h8000_0000;
   localparam word_type LOW_BITS  = 32'h7FFF_FFFF;

   localparam idx_type LAST_IDX  = idx_type'(STATE_DEPTH - 1);
   localparam idx_type DEPTH_IDX = idx_type'(STATE_DEPTH);
   localparam idx_type FAR_WRAP  = idx_type'(STATE_DEPTH - SHIFT_DIST);
   localparam idx_type SHIFT_OFS = idx_type'(SHIFT_DIST);

   localparam cmd_type CMD_RAW    = 2'd0;
   localparam cmd_type CMD_RANGED = 2'd1;
   localparam cmd_type CMD_RESEED = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SEED_MUL,
      ST_SEED_ADD,
      ST_REGEN_START,
      ST_REGEN_LOAD,
      ST_REGEN_READ,
      ST_REGEN_WRITE,
      ST_DRAW_READ,
      ST_DRAW_TEMPER,
      ST_MOD,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } mod_status_type;

   function automatic word_type temper(word_type w);
      word_type y;
      y = w ^ (w >> 11);
      y = y ^ ((y << 7) & TEMPER_B);
      y = y ^ ((y << 15) & TEMPER_C);
      y = y ^ (y >> 18);
      return y;
   endfunction

   function automatic word_type twist(word_type cur, word_type nxt, word_type far_word);
      word_type y;
      word_type v;
      y = (cur & HIGH_BIT) | (nxt & LOW_BITS);
      v = far_word ^ (y >> 1);
      if (y[0]) begin
         v = v ^ TWIST_MAT;
      end
      return v;
   endfunction

endpackage

// File: hw/rtl/mtg_mod_unit.sv
module mtg_mod_unit (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  mtg_pkg::word_type       dividend,
   input  mtg_pkg::word_type       divisor,
   output mtg_pkg::word_type       remainder,
   output mtg_pkg::mod_status_type status
);

   localparam logic [mtg_pkg::DIV_CNT_W-1:0] LAST_STEP =
      mtg_pkg::DIV_CNT_W'(mtg_pkg::DATA_W - 1);

   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;
   logic [mtg_pkg::DIV_CNT_W-1:0]   cnt_ff, cnt_in;
   mtg_pkg::word_type               rem_ff, rem_in;
   mtg_pkg::word_type               dvd_ff, dvd_in;
   mtg_pkg::word_type               dvs_ff, dvs_in;
   logic [mtg_pkg::DATA_W:0]        shifted;
   logic [mtg_pkg::DATA_W:0]        diff;
   logic                            fits;

   assign shifted = {rem_ff, dvd_ff[mtg_pkg::DATA_W-1]};
   assign diff    = shifted - {1'b0, dvs_ff};
   assign fits    = shifted >= {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         dvd_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? diff[mtg_pkg::DATA_W-1:0] : shifted[mtg_pkg::DATA_W-1:0];
         dvd_in = dvd_ff << 1;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
   end

   assign remainder   = rem_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

// File: hw/rtl/mersenne_twister_generator.sv
// MT19937 generator with a 624-word state memory and a read index.
// Request channel (req_valid/req_stall): req_cmd selects raw draw, ranged
// draw (req_range_bound is the exclusive bound) or reseed from the seed
// register; every transaction gives exactly one response on rsp_random_value.
// csr_write_enable/csr_write_data write the seed register; write only when idle.
// One transaction is in flight at a time; req_stall is high until the response
// has been loaded into the output register.
// A raw draw reads the state word and tempers it. When the whole state is
// regenerated first, each word takes a read state and a write state through
// the memory ports. A ranged draw adds the modulo unit (one remainder bit per
// cycle). Reseed takes one multiply and one add per word. Zero bound,
// unused command code and draws before the first reseed respond directly.
// The next transaction is accepted only once the response is loaded, so
// back-to-back raw draws do not overlap.
// Reset is synchronous; after it the seed register is zero and no clearing pass
// runs: until the first reseed every draw returns zero.
// A stalled response holds in the output register; a finished result waits
// in the core until the output register is free.
`include "mersenne_twister_generator_assert.svh"

module mersenne_twister_generator (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write_enable,
   input  logic [31:0]               csr_write_data,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [1:0]                req_cmd,
   input  logic [31:0]               req_range_bound,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [31:0]               rsp_random_value
);

   mtg_pkg::state_type      state_ff, state_in;
   mtg_pkg::idx_type        index_ff, index_in;
   logic                    seeded_ff, seeded_in;
   mtg_pkg::idx_type        k_ff, k_in;
   mtg_pkg::word_type       word_ff, word_in;
   mtg_pkg::word_type       prod_ff, prod_in;
   mtg_pkg::cmd_type        cmd_ff, cmd_in;
   mtg_pkg::word_type       bound_ff, bound_in;
   mtg_pkg::word_type       seed_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   mtg_pkg::word_type       rsp_value_ff, rsp_value_in;

   mtg_pkg::word_type       state_words_ff [mtg_pkg::STATE_DEPTH];
   mtg_pkg::word_type       rd_a_ff, rd_b_ff;
   logic                    mem_we;
   mtg_pkg::idx_type        mem_waddr, mem_raddr_a, mem_raddr_b;
   mtg_pkg::word_type       mem_wdata;

   logic                    accept;
   logic                    rsp_free;
   logic                    need_draw;
   mtg_pkg::idx_type        k_nxt, k_far;
   mtg_pkg::word_type       tempered, twisted, seed_mix, seed_word;

   logic                    mod_start;
   mtg_pkg::word_type       mod_rem;
   mtg_pkg::mod_status_type mod_status;

   mtg_mod_unit u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (tempered),
      .divisor   (bound_ff),
      .remainder (mod_rem),
      .status    (mod_status)
   );

   assign req_stall        = state_ff != mtg_pkg::ST_IDLE;
   assign accept           = req_valid && !req_stall;
   assign rsp_free         = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_random_value = rsp_value_ff;

   assign need_draw = (req_cmd == mtg_pkg::CMD_RAW) ||
                      ((req_cmd == mtg_pkg::CMD_RANGED) && (req_range_bound != '0));

   assign k_nxt = (k_ff == mtg_pkg::LAST_IDX) ? '0 : k_ff + 1'b1;
   assign k_far = (k_ff >= mtg_pkg::FAR_WRAP) ? k_ff - mtg_pkg::FAR_WRAP
                                              : k_ff + mtg_pkg::SHIFT_OFS;

   assign tempered  = mtg_pkg::temper(rd_a_ff);
   assign twisted   = mtg_pkg::twist(word_ff, rd_a_ff, rd_b_ff);
   assign seed_mix  = word_ff ^ (word_ff >> 30);
   assign seed_word = prod_ff + mtg_pkg::word_type'(k_ff);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mtg_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_cmd == mtg_pkg::CMD_RESEED) begin
                  state_in = mtg_pkg::ST_SEED_MUL;
               end else if (need_draw && seeded_ff) begin
                  state_in = (index_ff >= mtg_pkg::DEPTH_IDX) ? mtg_pkg::ST_REGEN_START
                                                              : mtg_pkg::ST_DRAW_READ;
               end else begin
                  state_in = mtg_pkg::ST_DONE;
               end
            end
         end
         mtg_pkg::ST_SEED_MUL:    state_in = mtg_pkg::ST_SEED_ADD;
         mtg_pkg::ST_SEED_ADD: begin
            state_in = (k_ff == mtg_pkg::LAST_IDX) ? mtg_pkg::ST_DONE : mtg_pkg::ST_SEED_MUL;
         end
         mtg_pkg::ST_REGEN_START: state_in = mtg_pkg::ST_REGEN_LOAD;
         mtg_pkg::ST_REGEN_LOAD:  state_in = mtg_pkg::ST_REGEN_READ;
         mtg_pkg::ST_REGEN_READ:  state_in = mtg_pkg::ST_REGEN_WRITE;
         mtg_pkg::ST_REGEN_WRITE: begin
            state_in = (k_ff == mtg_pkg::LAST_IDX) ? mtg_pkg::ST_DRAW_READ
                                                   : mtg_pkg::ST_REGEN_READ;
         end
         mtg_pkg::ST_DRAW_READ:   state_in = mtg_pkg::ST_DRAW_TEMPER;
         mtg_pkg::ST_DRAW_TEMPER: begin
            state_in = (cmd_ff == mtg_pkg::CMD_RANGED) ? mtg_pkg::ST_MOD : mtg_pkg::ST_DONE;
         end
         mtg_pkg::ST_MOD: begin
            if (mod_status.done) begin
               state_in = mtg_pkg::ST_DONE;
            end
         end
         mtg_pkg::ST_DONE: begin
            if (rsp_free) begin
               state_in = mtg_pkg::ST_IDLE;
            end
         end
         default:                 state_in = mtg_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      index_in     = index_ff;
      seeded_in    = seeded_ff;
      k_in         = k_ff;
      word_in      = word_ff;
      prod_in      = prod_ff;
      cmd_in       = cmd_ff;
      bound_in     = bound_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_value_in = rsp_value_ff;
      mem_we       = 1'b0;
      mem_waddr    = k_ff;
      mem_wdata    = seed_word;
      mem_raddr_a  = k_ff;
      mem_raddr_b  = k_ff;
      mod_start    = 1'b0;
      unique case (state_ff)
         mtg_pkg::ST_IDLE: begin
            if (accept) begin
               cmd_in   = req_cmd;
               bound_in = req_range_bound;
               word_in  = '0;
               if (req_cmd == mtg_pkg::CMD_RESEED) begin
                  mem_we    = 1'b1;
                  mem_waddr = '0;
                  mem_wdata = seed_ff;
                  word_in   = seed_ff;
                  k_in      = mtg_pkg::idx_type'(1);
                  seeded_in = 1'b1;
                  index_in  = mtg_pkg::DEPTH_IDX;
               end
            end
         end
         mtg_pkg::ST_SEED_MUL: begin
            prod_in = mtg_pkg::INIT_MULT * seed_mix;
         end
         mtg_pkg::ST_SEED_ADD: begin
            mem_we  = 1'b1;
            word_in = (k_ff == mtg_pkg::LAST_IDX) ? '0 : seed_word;
            k_in    = k_nxt;
         end
         mtg_pkg::ST_REGEN_START: begin
            mem_raddr_a = '0;
            k_in        = '0;
         end
         mtg_pkg::ST_REGEN_LOAD: begin
            word_in = rd_a_ff;
         end
         mtg_pkg::ST_REGEN_READ: begin
            mem_raddr_a = k_nxt;
            mem_raddr_b = k_far;
         end
         mtg_pkg::ST_REGEN_WRITE: begin
            mem_we    = 1'b1;
            mem_wdata = twisted;
            word_in   = rd_a_ff;
            k_in      = k_nxt;
            if (k_ff == mtg_pkg::LAST_IDX) begin
               index_in = '0;
            end
         end
         mtg_pkg::ST_DRAW_READ: begin
            mem_raddr_a = index_ff;
            index_in    = index_ff + 1'b1;
         end
         mtg_pkg::ST_DRAW_TEMPER: begin
            word_in   = tempered;
            mod_start = cmd_ff == mtg_pkg::CMD_RANGED;
         end
         mtg_pkg::ST_MOD: begin
            if (mod_status.done) begin
               word_in = mod_rem;
            end
         end
         mtg_pkg::ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = word_ff;
            end
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         state_words_ff[mem_waddr] <= mem_wdata;
      end
      rd_a_ff <= state_words_ff[mem_raddr_a];
      rd_b_ff <= state_words_ff[mem_raddr_b];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mtg_pkg::ST_IDLE;
         index_ff     <= '0;
         seeded_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         seed_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         index_ff     <= index_in;
         seeded_ff    <= seeded_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            seed_ff <= csr_write_data;
         end
      end
      k_ff         <= k_in;
      word_ff      <= word_in;
      prod_ff      <= prod_in;
      cmd_ff       <= cmd_in;
      bound_ff     <= bound_in;
      rsp_value_ff <= rsp_value_in;
   end

   `MTG_ASSERT_NXT(a_accept_blocks, clock, reset, req_valid && !req_stall, req_stall)
   `MTG_ASSERT_IMP(a_draw_index_ok, clock, reset, state_ff == mtg_pkg::ST_DRAW_READ, index_ff < mtg_pkg::DEPTH_IDX)
   `MTG_ASSERT_IMP(a_mod_busy_in_mod, clock, reset, mod_status.busy, state_ff == mtg_pkg::ST_MOD)
   `MTG_ASSERT_NXT(a_done_delivers, clock, reset, state_ff == mtg_pkg::ST_DONE && rsp_free, rsp_valid && state_ff == mtg_pkg::ST_IDLE)

endmodule
